// File: hw/rtl/cdp_pkg.sv
// Shared types and constants for the datetime string parser.
// Holds word structs, the token passed from front to back, and field limits.
`timescale 1ns / 1ps

package cdp_pkg;

	localparam int POS_W     = 5;
	localparam int YEAR_W    = 14;
	localparam int FLD_W     = 7;
	localparam int OFS_W     = 10;
	localparam int DIGIT_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [POS_W-1:0] STR_LEN          = POS_W'(25);
	localparam logic [POS_W-1:0] DATE_TIME_DIGITS = POS_W'(8 + 6);
	localparam logic [POS_W-1:0] DOT_POS          = DATE_TIME_DIGITS;
	localparam logic [POS_W-1:0] SIGN_POS         = POS_W'(21);

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = YEAR_W'(1900);
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = YEAR_W'(9999);
	localparam logic [FLD_W-1:0]  MONTH_MAX    = FLD_W'(12);
	localparam logic [FLD_W-1:0]  DAY_MAX      = FLD_W'(31);
	localparam logic [FLD_W-1:0]  HOURS_MAX    = FLD_W'(23);
	localparam logic [FLD_W-1:0]  MINSEC_MAX   = FLD_W'(59);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_YEAR,
		REG_MAX_YEAR
	} reg_idx_t;

	typedef enum logic [3:0] {
		K_NONE,
		K_YEAR,
		K_MONTH,
		K_DAY,
		K_HOURS,
		K_MINUTES,
		K_SECONDS,
		K_SIGN,
		K_OFFSET
	} kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic              ok;
		logic [YEAR_W-1:0] year;
		logic [FLD_W-1:0]  month;
		logic [FLD_W-1:0]  day;
		logic [FLD_W-1:0]  hours;
		logic [FLD_W-1:0]  minutes;
		logic [FLD_W-1:0]  seconds;
		logic              offset_negative;
		logic [OFS_W-1:0]  offset_minutes;
	} out_t;

	typedef struct packed {
		kind_t              kind;
		logic [DIGIT_W-1:0] digit;
		logic               minus;
		logic               bad;
		logic               full;
		logic               last;
	} tok_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year_floor;
		logic [YEAR_W-1:0] year_ceiling;
	} cfg_t;

	function automatic logic [YEAR_W-1:0] push_digit(
		input logic [YEAR_W-1:0]  acc,
		input logic [DIGIT_W-1:0] d
	);
		push_digit = (acc << 3) + (acc << 1) + YEAR_W'(d);
	endfunction

endpackage

// File: hw/rtl/cdp_front.sv
// Front end of the datetime string parser: position tracking and format checks.
// Turns each accepted character into a token for the back end; uses cdp_pkg.
`timescale 1ns / 1ps

module cdp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_stall,
	input  cdp_pkg::in_t   char_word,
	input  logic           q_full,
	output logic           q_push,
	output cdp_pkg::tok_t  q_tok
);

	logic [cdp_pkg::POS_W-1:0] pos_q;
	logic                      err_q;
	logic [7:0]                c;
	logic                      is_digit;
	logic                      over;
	logic                      err_now;
	cdp_pkg::kind_t            kind;
	logic                      minus;

	assign c          = char_word.char_code;
	assign is_digit   = (c >= cdp_pkg::CH_ZERO) && (c <= cdp_pkg::CH_NINE);
	assign over       = pos_q >= cdp_pkg::STR_LEN;
	assign char_stall = q_full;
	assign q_push     = char_valid && !q_full;

	always_comb begin
		kind    = cdp_pkg::K_NONE;
		minus   = 1'b0;
		err_now = err_q;
		if (over) begin
			err_now = 1'b1;
		end else if (pos_q == cdp_pkg::DOT_POS) begin
			if (c != cdp_pkg::CH_DOT) err_now = 1'b1;
		end else if (pos_q == cdp_pkg::SIGN_POS) begin
			if (c == cdp_pkg::CH_PLUS) begin
				kind = cdp_pkg::K_SIGN;
			end else if (c == cdp_pkg::CH_MINUS) begin
				kind  = cdp_pkg::K_SIGN;
				minus = 1'b1;
			end else begin
				err_now = 1'b1;
			end
		end else if (!is_digit) begin
			err_now = 1'b1;
		end else begin
			case (pos_q) inside
				[5'd0:5'd3]:   kind = cdp_pkg::K_YEAR;
				[5'd4:5'd5]:   kind = cdp_pkg::K_MONTH;
				[5'd6:5'd7]:   kind = cdp_pkg::K_DAY;
				[5'd8:5'd9]:   kind = cdp_pkg::K_HOURS;
				[5'd10:5'd11]: kind = cdp_pkg::K_MINUTES;
				[5'd12:5'd13]: kind = cdp_pkg::K_SECONDS;
				[5'd22:5'd24]: kind = cdp_pkg::K_OFFSET;
				default:       kind = cdp_pkg::K_NONE;
			endcase
		end
	end

	always_comb begin
		q_tok.kind  = kind;
		q_tok.digit = cdp_pkg::DIGIT_W'(c - cdp_pkg::CH_ZERO);
		q_tok.minus = minus;
		q_tok.bad   = err_now;
		q_tok.full  = pos_q == (cdp_pkg::STR_LEN - cdp_pkg::POS_W'(1));
		q_tok.last  = char_word.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
		end else if (q_push) begin
			if (char_word.is_last) begin
				pos_q <= '0;
				err_q <= 1'b0;
			end else begin
				pos_q <= over ? pos_q : pos_q + cdp_pkg::POS_W'(1);
				err_q <= err_now;
			end
		end
	end

endmodule

// File: hw/rtl/cdp_queue.sv
// Token queue between front and back of the datetime string parser.
// Small register FIFO of cdp_pkg::tok_t entries; the user must keep DEPTH at least 2 (not enforced).
`timescale 1ns / 1ps

module cdp_queue #(
	parameter int DEPTH = cdp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cdp_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output cdp_pkg::tok_t head_tok
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cdp_pkg::tok_t    mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign head_tok = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + IDX_W'(1);
			if (pop)  rd_q <= (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + IDX_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// File: hw/rtl/cdp_back.sv
// Back end of the datetime string parser: field accumulation and range checks.
// Drains tokens from cdp_queue and holds the result word; uses cdp_pkg.
`timescale 1ns / 1ps

module cdp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cdp_pkg::cfg_t cfg,
	input  logic          q_nonempty,
	input  cdp_pkg::tok_t tok,
	output logic          q_pop,
	output logic          res_valid,
	input  logic          res_stall,
	output cdp_pkg::out_t res_word
);

	logic [cdp_pkg::YEAR_W-1:0] year_q, year_nx;
	logic [cdp_pkg::FLD_W-1:0]  month_q, month_nx;
	logic [cdp_pkg::FLD_W-1:0]  day_q, day_nx;
	logic [cdp_pkg::FLD_W-1:0]  hours_q, hours_nx;
	logic [cdp_pkg::FLD_W-1:0]  minutes_q, minutes_nx;
	logic [cdp_pkg::FLD_W-1:0]  seconds_q, seconds_nx;
	logic                       minus_q, minus_nx;
	logic [cdp_pkg::OFS_W-1:0]  offset_q, offset_nx;
	logic                       valid_q;
	cdp_pkg::out_t              res_q;
	cdp_pkg::out_t              res_nx;
	logic                       slot_free;
	logic                       ok;

	assign slot_free = !valid_q || !res_stall;
	assign q_pop     = q_nonempty && (!tok.last || slot_free);
	assign res_valid = valid_q;
	assign res_word  = res_q;

	always_comb begin
		year_nx    = year_q;
		month_nx   = month_q;
		day_nx     = day_q;
		hours_nx   = hours_q;
		minutes_nx = minutes_q;
		seconds_nx = seconds_q;
		minus_nx   = minus_q;
		offset_nx  = offset_q;
		case (tok.kind)
			cdp_pkg::K_YEAR:    year_nx = cdp_pkg::push_digit(year_q, tok.digit);
			cdp_pkg::K_MONTH:   month_nx = cdp_pkg::FLD_W'(cdp_pkg::push_digit(
				cdp_pkg::YEAR_W'(month_q), tok.digit));
			cdp_pkg::K_DAY:     day_nx = cdp_pkg::FLD_W'(cdp_pkg::push_digit(
				cdp_pkg::YEAR_W'(day_q), tok.digit));
			cdp_pkg::K_HOURS:   hours_nx = cdp_pkg::FLD_W'(cdp_pkg::push_digit(
				cdp_pkg::YEAR_W'(hours_q), tok.digit));
			cdp_pkg::K_MINUTES: minutes_nx = cdp_pkg::FLD_W'(cdp_pkg::push_digit(
				cdp_pkg::YEAR_W'(minutes_q), tok.digit));
			cdp_pkg::K_SECONDS: seconds_nx = cdp_pkg::FLD_W'(cdp_pkg::push_digit(
				cdp_pkg::YEAR_W'(seconds_q), tok.digit));
			cdp_pkg::K_SIGN:    minus_nx = tok.minus;
			cdp_pkg::K_OFFSET:  offset_nx = cdp_pkg::OFS_W'(cdp_pkg::push_digit(
				cdp_pkg::YEAR_W'(offset_q), tok.digit));
			default: ;
		endcase
	end

	always_comb begin
		ok = !tok.bad && tok.full
			&& year_nx >= cfg.year_floor && year_nx <= cfg.year_ceiling
			&& month_nx >= cdp_pkg::FLD_W'(1) && month_nx <= cdp_pkg::MONTH_MAX
			&& day_nx >= cdp_pkg::FLD_W'(1) && day_nx <= cdp_pkg::DAY_MAX
			&& hours_nx <= cdp_pkg::HOURS_MAX
			&& minutes_nx <= cdp_pkg::MINSEC_MAX
			&& seconds_nx <= cdp_pkg::MINSEC_MAX;
		res_nx = '0;
		if (ok) begin
			res_nx.ok              = 1'b1;
			res_nx.year            = year_nx;
			res_nx.month           = month_nx;
			res_nx.day             = day_nx;
			res_nx.hours           = hours_nx;
			res_nx.minutes         = minutes_nx;
			res_nx.seconds         = seconds_nx;
			res_nx.offset_negative = minus_nx;
			res_nx.offset_minutes  = offset_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && tok.last) res_q <= res_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			minus_q   <= 1'b0;
			offset_q  <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				if (tok.last) begin
					year_q    <= '0;
					month_q   <= '0;
					day_q     <= '0;
					hours_q   <= '0;
					minutes_q <= '0;
					seconds_q <= '0;
					minus_q   <= 1'b0;
					offset_q  <= '0;
				end else begin
					year_q    <= year_nx;
					month_q   <= month_nx;
					day_q     <= day_nx;
					hours_q   <= hours_nx;
					minutes_q <= minutes_nx;
					seconds_q <= seconds_nx;
					minus_q   <= minus_nx;
					offset_q  <= offset_nx;
				end
			end
			if (q_pop && tok.last) valid_q <= 1'b1;
			else if (!res_stall)   valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/cim_datetime_string_parser.sv
// Top level of the datetime string parser: year limit registers and assertions.
// Instantiates cdp_front, cdp_queue and cdp_back; uses cdp_pkg.
`timescale 1ns / 1ps

// Takes one character word per cycle on the char channel while char_stall is low, with
// is_last marking the end of a string of the form YYYYMMDDHHMMSS.FFFFFF+TZO, and gives one
// result word per string on the res channel; the last character is registered in the token
// queue and then its result in the result register, which holds while res is stalled.
// A new string may follow its predecessor with no gap. The front end checks position and
// format, a token queue of QUEUE_DEPTH entries decouples it from the back end, which folds
// one decimal digit per cycle into the fields and registers the result, so the sustained
// rate is one character per cycle while res is not stalled. A failed string gives ok = 0
// with all fields zero. Registers: index 0 lowest accepted year (reset 1900), index 1 highest
// accepted year (reset 9999); the user must write them only while the block is idle (not enforced).

module cim_datetime_string_parser #(
	parameter int QUEUE_DEPTH = cdp_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  cdp_pkg::in_t                  char_word,
	output logic                          res_valid,
	input  logic                          res_stall,
	output cdp_pkg::out_t                 res_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdp_pkg::YEAR_W-1:0]    cfg_data
);

	cdp_pkg::cfg_t cfg_q;
	cdp_pkg::tok_t push_tok;
	cdp_pkg::tok_t head_tok;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_nonempty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.year_floor   <= cdp_pkg::MIN_YEAR_RST;
			cfg_q.year_ceiling <= cdp_pkg::MAX_YEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cdp_pkg::reg_idx_t'(cfg_index))
				cdp_pkg::REG_MIN_YEAR: cfg_q.year_floor <= cfg_data;
				cdp_pkg::REG_MAX_YEAR: cfg_q.year_ceiling <= cfg_data;
				default: ;
			endcase
		end
	end

	cdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_tok      (push_tok)
	);

	cdp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head_tok (head_tok)
	);

	cdp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.tok        (head_tok),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word)
	);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.ok |-> res_word.year == '0 && res_word.month == '0
			&& res_word.day == '0 && res_word.hours == '0 && res_word.minutes == '0
			&& res_word.seconds == '0 && !res_word.offset_negative
			&& res_word.offset_minutes == '0)
		else $error("failed result carries nonzero fields");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.ok |-> res_word.year >= cfg_q.year_floor
			&& res_word.year <= cfg_q.year_ceiling
			&& res_word.month >= cdp_pkg::FLD_W'(1) && res_word.month <= cdp_pkg::MONTH_MAX
			&& res_word.day >= cdp_pkg::FLD_W'(1) && res_word.day <= cdp_pkg::DAY_MAX)
		else $error("accepted date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.ok |-> res_word.hours <= cdp_pkg::HOURS_MAX
			&& res_word.minutes <= cdp_pkg::MINSEC_MAX
			&& res_word.seconds <= cdp_pkg::MINSEC_MAX)
		else $error("accepted time out of range");

endmodule

// File: bench/cim_datetime_string_parser_test.sv
// Self-checking bench for cim_datetime_string_parser: directed timestamp strings, most checked against
// their own expected word, then random strings under a series of year limits, checked by a built-in parser model.
// Depends on cdp_pkg and the cim_datetime_string_parser RTL only.
`timescale 1ns / 1ps

module cim_datetime_string_parser_test;

	localparam int RANDOM_CHARS = 800;
	localparam int RUNS_PER_SETTING = 6;
	localparam int MAX_PRINTS = 40;
	localparam cdp_pkg::out_t BAD_STAMP = '0;

	typedef struct {
		string         text;
		int            patch_at;
		logic [7:0]    patch_code;
		bit            typed;
		cdp_pkg::out_t want;
	} stamp_row_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          char_valid = 1'b0;
	logic                          char_stall;
	cdp_pkg::in_t                  char_word = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	cdp_pkg::out_t                 res_word;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [cdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cdp_pkg::YEAR_W-1:0]    cfg_data = '0;

	// parser model state
	logic [cdp_pkg::POS_W-1:0]  sp_pos = '0;
	logic                       sp_bad = 1'b0;
	logic [cdp_pkg::YEAR_W-1:0] sp_year = '0;
	logic [cdp_pkg::FLD_W-1:0]  sp_month = '0;
	logic [cdp_pkg::FLD_W-1:0]  sp_day = '0;
	logic [cdp_pkg::FLD_W-1:0]  sp_hours = '0;
	logic [cdp_pkg::FLD_W-1:0]  sp_minutes = '0;
	logic [cdp_pkg::FLD_W-1:0]  sp_seconds = '0;
	logic                       sp_minus = 1'b0;
	logic [cdp_pkg::OFS_W-1:0]  sp_offset = '0;
	logic [cdp_pkg::YEAR_W-1:0] year_lo = cdp_pkg::MIN_YEAR_RST;
	logic [cdp_pkg::YEAR_W-1:0] year_hi = cdp_pkg::MAX_YEAR_RST;

	cdp_pkg::out_t pending_stamps[$];
	cdp_pkg::out_t head_stamp;
	stamp_row_t    directed_rows[$];
	logic [7:0]    run_codes[$];
	bit            run_lasts[$];

	int mismatches = 0;
	int chars_sent = 0;
	int stamps_seen = 0;
	int stamps_ok = 0;
	int settings_used = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	cim_datetime_string_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_word(char_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("** cim_datetime_string_parser: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t: result %0d %s: got %0d, want %0d", $time, stamps_seen, what, got,
				want);
	endtask

	task automatic parse_char(input logic [7:0] c, input logic last,
		output cdp_pkg::out_t stamp, output bit done);
		logic [cdp_pkg::POS_W-1:0] at;
		logic [3:0]                d;
		bit                        digit;
		bit                        good;
		digit = (c >= cdp_pkg::CH_ZERO) && (c <= cdp_pkg::CH_NINE);
		d = 4'(c - cdp_pkg::CH_ZERO);
		stamp = BAD_STAMP;
		done = 1'b0;
		if (sp_pos >= cdp_pkg::STR_LEN) begin
			sp_bad = 1'b1;
		end else begin
			at = sp_pos;
			sp_pos = sp_pos + 1'b1;
			if (at == cdp_pkg::DOT_POS) begin
				if (c != cdp_pkg::CH_DOT)
					sp_bad = 1'b1;
			end else if (at == cdp_pkg::SIGN_POS) begin
				if (c == cdp_pkg::CH_PLUS)
					sp_minus = 1'b0;
				else if (c == cdp_pkg::CH_MINUS)
					sp_minus = 1'b1;
				else
					sp_bad = 1'b1;
			end else if (!digit) begin
				sp_bad = 1'b1;
			end else if (at < 4) begin
				sp_year = cdp_pkg::YEAR_W'(sp_year * 10 + d);
			end else if (at < 6) begin
				sp_month = cdp_pkg::FLD_W'(sp_month * 10 + d);
			end else if (at < 8) begin
				sp_day = cdp_pkg::FLD_W'(sp_day * 10 + d);
			end else if (at < 10) begin
				sp_hours = cdp_pkg::FLD_W'(sp_hours * 10 + d);
			end else if (at < 12) begin
				sp_minutes = cdp_pkg::FLD_W'(sp_minutes * 10 + d);
			end else if (at < cdp_pkg::DATE_TIME_DIGITS) begin
				sp_seconds = cdp_pkg::FLD_W'(sp_seconds * 10 + d);
			end else if (at > cdp_pkg::SIGN_POS) begin
				sp_offset = cdp_pkg::OFS_W'(sp_offset * 10 + d);
			end
		end
		if (last) begin
			done = 1'b1;
			good = !sp_bad && sp_pos == cdp_pkg::STR_LEN
				&& sp_year >= year_lo && sp_year <= year_hi
				&& sp_month >= 1 && sp_month <= cdp_pkg::MONTH_MAX
				&& sp_day >= 1 && sp_day <= cdp_pkg::DAY_MAX
				&& sp_hours <= cdp_pkg::HOURS_MAX
				&& sp_minutes <= cdp_pkg::MINSEC_MAX
				&& sp_seconds <= cdp_pkg::MINSEC_MAX;
			if (good) begin
				stamp.ok = 1'b1;
				stamp.year = sp_year;
				stamp.month = sp_month;
				stamp.day = sp_day;
				stamp.hours = sp_hours;
				stamp.minutes = sp_minutes;
				stamp.seconds = sp_seconds;
				stamp.offset_negative = sp_minus;
				stamp.offset_minutes = sp_offset;
			end
			sp_pos = '0;
			sp_bad = 1'b0;
			sp_year = '0;
			sp_month = '0;
			sp_day = '0;
			sp_hours = '0;
			sp_minutes = '0;
			sp_seconds = '0;
			sp_minus = 1'b0;
			sp_offset = '0;
		end
	endtask

	function automatic cdp_pkg::out_t good_stamp(int y, int mo, int dd, int h, int mi, int s,
		bit neg, int ofs);
		cdp_pkg::out_t r;
		r.ok = 1'b1;
		r.year = cdp_pkg::YEAR_W'(y);
		r.month = cdp_pkg::FLD_W'(mo);
		r.day = cdp_pkg::FLD_W'(dd);
		r.hours = cdp_pkg::FLD_W'(h);
		r.minutes = cdp_pkg::FLD_W'(mi);
		r.seconds = cdp_pkg::FLD_W'(s);
		r.offset_negative = neg;
		r.offset_minutes = cdp_pkg::OFS_W'(ofs);
		return r;
	endfunction

	function automatic void add_row(string text, int patch_at, logic [7:0] patch_code,
		bit typed, cdp_pkg::out_t want);
		stamp_row_t r;
		r.text = text;
		r.patch_at = patch_at;
		r.patch_code = patch_code;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic int pick_year();
		case ($urandom_range(0, 7))
			0: return year_lo;
			1: return year_hi;
			2: return (year_lo > 0) ? year_lo - 1 : 0;
			3: return (year_hi < 9999) ? year_hi + 1 : 9999;
			4: return $urandom_range(0, 9999);
			default: return $urandom_range(year_lo, year_hi);
		endcase
	endfunction

	function automatic int pick_field(int lo, int hi);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
	endfunction

	task automatic build_random_run();
		int    flavor;
		int    n;
		string txt;
		flavor = $urandom_range(0, 99);
		run_codes.delete();
		run_lasts.delete();
		if (flavor >= 90) begin
			n = $urandom_range(1, 30);
			repeat (n) begin
				run_codes.push_back(8'($urandom_range(0, 255)));
				run_lasts.push_back($urandom_range(0, 9) == 0);
			end
			run_lasts[n - 1] = 1'b1;
		end else begin
			txt = $sformatf("%04d%02d%02d%02d%02d%02d.%06d%s%03d", pick_year(),
				pick_field(1, 12), pick_field(1, 31), pick_field(0, 23), pick_field(0, 59),
				pick_field(0, 59), $urandom_range(0, 999999),
				$urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 999));
			for (int i = 0; i < txt.len(); i++)
				run_codes.push_back(txt[i]);
			if (flavor >= 70 && flavor < 82)
				run_codes[$urandom_range(0, 24)] = 8'($urandom_range(0, 255));
			else if (flavor >= 82 && flavor < 86)
				repeat ($urandom_range(1, 24)) void'(run_codes.pop_back());
			else if (flavor >= 86)
				repeat ($urandom_range(1, 4)) run_codes.push_back(8'($urandom_range(48, 57)));
			foreach (run_codes[i])
				run_lasts.push_back(i == run_codes.size() - 1);
		end
	endtask

	task automatic send_run(input bit typed, input cdp_pkg::out_t want);
		cdp_pkg::out_t stamp;
		bit            done;
		foreach (run_codes[i]) begin
			if (burst_left == 0) begin
				char_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 12);
			end
			char_valid <= 1'b1;
			char_word <= '{char_code: run_codes[i], is_last: run_lasts[i]};
			@(posedge clk);
			while (char_stall)
				@(posedge clk);
			parse_char(run_codes[i], run_lasts[i], stamp, done);
			chars_sent++;
			if (done)
				pending_stamps.push_back(typed ? want : stamp);
			burst_left--;
			@(negedge clk);
		end
	endtask

	task automatic settle();
		char_valid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_year_limits(input int lo, input int hi);
		cfg_valid <= 1'b1;
		cfg_index <= cdp_pkg::REG_MIN_YEAR;
		cfg_data <= cdp_pkg::YEAR_W'(lo);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		year_lo = cdp_pkg::YEAR_W'(lo);
		@(negedge clk);
		cfg_index <= cdp_pkg::REG_MAX_YEAR;
		cfg_data <= cdp_pkg::YEAR_W'(hi);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		year_hi = cdp_pkg::YEAR_W'(hi);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 40);
		end
		stall_left--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 1) == 1);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_stamps.size() == 0) begin
				report_mismatch("unexpected word, ok", res_word.ok, 0);
			end else begin
				head_stamp = pending_stamps.pop_front();
				if (res_word.ok !== head_stamp.ok)
					report_mismatch("ok", res_word.ok, head_stamp.ok);
				if (res_word.year !== head_stamp.year)
					report_mismatch("year", res_word.year, head_stamp.year);
				if (res_word.month !== head_stamp.month)
					report_mismatch("month", res_word.month, head_stamp.month);
				if (res_word.day !== head_stamp.day)
					report_mismatch("day", res_word.day, head_stamp.day);
				if (res_word.hours !== head_stamp.hours)
					report_mismatch("hours", res_word.hours, head_stamp.hours);
				if (res_word.minutes !== head_stamp.minutes)
					report_mismatch("minutes", res_word.minutes, head_stamp.minutes);
				if (res_word.seconds !== head_stamp.seconds)
					report_mismatch("seconds", res_word.seconds, head_stamp.seconds);
				if (res_word.offset_negative !== head_stamp.offset_negative)
					report_mismatch("offset_negative", res_word.offset_negative,
						head_stamp.offset_negative);
				if (res_word.offset_minutes !== head_stamp.offset_minutes)
					report_mismatch("offset_minutes", res_word.offset_minutes,
						head_stamp.offset_minutes);
				if (head_stamp.ok)
					stamps_ok++;
				stamps_seen++;
			end
		end
	end

	initial begin
		int lo_list[5];
		int hi_list[5];
		int lo;
		int hi;
		int swap;
		int phase;
		int random_start;
		lo_list = '{1900, 0, 0, 9999, 5000};
		hi_list = '{9999, 9999, 0, 9999, 4000};

		add_row("20240229120000.000000+060", -1, 8'h00, 1,
			good_stamp(2024, 2, 29, 12, 0, 0, 0, 60));
		add_row("19000101000000.000000-000", -1, 8'h00, 1,
			good_stamp(1900, 1, 1, 0, 0, 0, 1, 0));
		add_row("99991231235959.999999+999", -1, 8'h00, 1,
			good_stamp(9999, 12, 31, 23, 59, 59, 0, 999));
		add_row("18991231235959.999999+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("00000101000000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20241301000000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240001000000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240100000000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240132000000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101240000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101006000.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101000060.000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101000000,000000+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101000000.000000*000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101000000.0000a0+000", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101000000.000000+00x", -1, 8'h00, 1, BAD_STAMP);
		add_row("2024010100000", -1, 8'h00, 1, BAD_STAMP);
		add_row("7", -1, 8'h00, 1, BAD_STAMP);
		add_row("20240101000000.000000+0000", -1, 8'h00, 1, BAD_STAMP);
		add_row("19991231235959.000000+000", 0, 8'hFF, 1, BAD_STAMP);
		add_row("19991231235959.000000+000", 21, 8'h00, 1, BAD_STAMP);
		add_row("20770704183015.250000-330", -1, 8'h00, 0, BAD_STAMP);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			run_codes.delete();
			run_lasts.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++) begin
				run_codes.push_back((i == directed_rows[r].patch_at) ?
					directed_rows[r].patch_code : directed_rows[r].text[i]);
				run_lasts.push_back(i == directed_rows[r].text.len() - 1);
			end
			send_run(directed_rows[r].typed, directed_rows[r].want);
		end

		random_start = chars_sent;
		phase = 0;
		while (chars_sent - random_start < RANDOM_CHARS) begin
			if (phase < 5) begin
				lo = lo_list[phase];
				hi = hi_list[phase];
			end else begin
				lo = $urandom_range(0, 9999);
				hi = lo + $urandom_range(0, 300);
				if (hi > 9999)
					hi = 9999;
				if ($urandom_range(0, 5) == 0) begin
					swap = lo;
					lo = hi;
					hi = swap;
				end
			end
			settle();
			write_year_limits(lo, hi);
			repeat (RUNS_PER_SETTING) begin
				build_random_run();
				send_run(1'b0, BAD_STAMP);
			end
			phase++;
		end
		settle();
		repeat (12) @(negedge clk);

		$display("%0d characters sent under %0d year-limit settings after the reset limits",
			chars_sent, settings_used);
		$display("%0d timestamps checked, %0d of them valid", stamps_seen, stamps_ok);
		if (mismatches == 0)
			$display("** cim_datetime_string_parser: PASSED **");
		else
			$display("** cim_datetime_string_parser: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/cdp_pkg.sv
hw/rtl/cdp_front.sv
hw/rtl/cdp_queue.sv
hw/rtl/cdp_back.sv
hw/rtl/cim_datetime_string_parser.sv
bench/cim_datetime_string_parser_test.sv
